FILE: rtl/core/ald_pkg.sv
// Shared types, label codes and divisor constants for the ARINC 429 label decoder.
package ald_pkg;

    localparam int OUT_FRAC_BITS = 32;
    localparam int M_W           = 52;
    localparam int VAL_W         = 64;
    localparam int CORR_W        = 32;
    localparam int COARSE_W      = 21;
    localparam int SH_W          = 6;
    localparam int N_STAGE       = 7;

    localparam logic [1:0] CFG_PITCH   = 2'd0;
    localparam logic [1:0] CFG_ROLL    = 2'd1;
    localparam logic [1:0] CFG_HEADING = 2'd2;

    localparam logic [1:0] SSM_NO_DATA = 2'b01;
    localparam logic [1:0] SSM_TEST    = 2'b10;
    localparam logic [1:0] SSM_MINUS   = 2'b11;

    localparam logic [7:0] LBL_007 = 8'o007, LBL_010 = 8'o010, LBL_011 = 8'o011;
    localparam logic [7:0] LBL_012 = 8'o012, LBL_013 = 8'o013, LBL_014 = 8'o014;
    localparam logic [7:0] LBL_044 = 8'o044, LBL_015 = 8'o015, LBL_016 = 8'o016;
    localparam logic [7:0] LBL_351 = 8'o351, LBL_126 = 8'o126, LBL_132 = 8'o132;
    localparam logic [7:0] LBL_137 = 8'o137, LBL_135 = 8'o135, LBL_175 = 8'o175;
    localparam logic [7:0] LBL_300 = 8'o300, LBL_301 = 8'o301, LBL_302 = 8'o302;
    localparam logic [7:0] LBL_303 = 8'o303, LBL_304 = 8'o304, LBL_305 = 8'o305;
    localparam logic [7:0] LBL_254 = 8'o254, LBL_255 = 8'o255, LBL_256 = 8'o256;
    localparam logic [7:0] LBL_257 = 8'o257, LBL_310 = 8'o310, LBL_311 = 8'o311;
    localparam logic [7:0] LBL_312 = 8'o312, LBL_324 = 8'o324, LBL_325 = 8'o325;
    localparam logic [7:0] LBL_314 = 8'o314, LBL_313 = 8'o313, LBL_316 = 8'o316;
    localparam logic [7:0] LBL_317 = 8'o317, LBL_320 = 8'o320, LBL_334 = 8'o334;
    localparam logic [7:0] LBL_321 = 8'o321, LBL_322 = 8'o322, LBL_315 = 8'o315;
    localparam logic [7:0] LBL_323 = 8'o323, LBL_331 = 8'o331, LBL_332 = 8'o332;
    localparam logic [7:0] LBL_333 = 8'o333, LBL_362 = 8'o362, LBL_363 = 8'o363;
    localparam logic [7:0] LBL_364 = 8'o364, LBL_375 = 8'o375, LBL_376 = 8'o376;
    localparam logic [7:0] LBL_370 = 8'o370, LBL_326 = 8'o326, LBL_327 = 8'o327;
    localparam logic [7:0] LBL_330 = 8'o330, LBL_336 = 8'o336, LBL_337 = 8'o337;
    localparam logic [7:0] LBL_335 = 8'o335, LBL_354 = 8'o354, LBL_245 = 8'o245;
    localparam logic [7:0] LBL_360 = 8'o360, LBL_365 = 8'o365, LBL_261 = 8'o261;
    localparam logic [7:0] LBL_361 = 8'o361, LBL_264 = 8'o264, LBL_266 = 8'o266;
    localparam logic [7:0] LBL_267 = 8'o267, LBL_366 = 8'o366, LBL_367 = 8'o367;

    typedef enum logic [3:0] {
        Q_1, Q_10, Q_600, Q_900, Q_1250, Q_2000, Q_20000, Q_75000, Q_DEG
    } t_qsel;

    typedef struct packed {
        logic            raw;
        logic            ok;
        logic            neg;
        t_qsel           qsel;
        logic [SH_W-1:0] shl;
        logic [SH_W-1:0] k;
    } t_meta;

    localparam logic [63:0] ALL1      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] RCP_10    = ALL1 / 64'd10;
    localparam logic [63:0] RCP_600   = ALL1 / 64'd600;
    localparam logic [63:0] RCP_900   = ALL1 / 64'd900;
    localparam logic [63:0] RCP_1250  = ALL1 / 64'd1250;
    localparam logic [63:0] RCP_2000  = ALL1 / 64'd2000;
    localparam logic [63:0] RCP_20000 = ALL1 / 64'd20000;
    localparam logic [63:0] RCP_75000 = ALL1 / 64'd75000;
    localparam logic [63:0] RCP_DEG   = ALL1 / 64'd5419351;

    function automatic logic [31:0] q_value(t_qsel qs);
        logic [31:0] r;
        unique case (qs)
            Q_10:    r = 32'd10;
            Q_600:   r = 32'd600;
            Q_900:   r = 32'd900;
            Q_1250:  r = 32'd1250;
            Q_2000:  r = 32'd2000;
            Q_20000: r = 32'd20000;
            Q_75000: r = 32'd75000;
            Q_DEG:   r = 32'd5419351;
            default: r = 32'd1;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] q_recip(t_qsel qs);
        logic [63:0] r;
        unique case (qs)
            Q_10:    r = RCP_10;
            Q_600:   r = RCP_600;
            Q_900:   r = RCP_900;
            Q_1250:  r = RCP_1250;
            Q_2000:  r = RCP_2000;
            Q_20000: r = RCP_20000;
            Q_75000: r = RCP_75000;
            Q_DEG:   r = RCP_DEG;
            default: r = ALL1;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/arinc429_label_decoder.sv
// Top level of the ARINC 429 label decoder: handshake, settings registers, pipeline control.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_word[31:0]
//   output   out        o_valid / i_stall    o_value[63:0], o_is_raw, o_valid_res
//   config   in         i_cfg_we             i_cfg_index[1:0], i_cfg_data[31:0]
//
// One transaction per cycle sustained while i_stall is low; each passes through the input
// register, the decode register and the five stages of the reciprocal divider to o_value.
// Reset clears the pipeline valid bits, the corrections and the coarse positions.
// Each stage holds while the one after it is full and stalled, so a stall on the output
// only reaches o_stall once every stage is occupied.
module arinc429_label_decoder
    import ald_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [31:0]             i_word,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_is_raw,
    output logic                    o_valid_res,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [CORR_W-1:0]       i_cfg_data
);

    logic [N_STAGE-1:0]       r_valid;
    logic [N_STAGE-1:0]       ready;
    logic [31:0]              r_word;
    logic signed [CORR_W-1:0] r_pitch, r_roll, r_heading;
    logic signed [M_W-1:0]    dec_m;
    t_meta                    dec_meta;

    always_comb begin
        ready[N_STAGE-1] = !r_valid[N_STAGE-1] || !i_stall;
        for (int i = N_STAGE - 2; i >= 0; i--) begin
            ready[i] = !r_valid[i] || ready[i+1];
        end
    end

    assign o_stall = !ready[0];
    assign o_valid = r_valid[N_STAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (ready[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int i = 1; i < N_STAGE; i++) begin
                if (ready[i]) begin
                    r_valid[i] <= r_valid[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready[0]) begin
            r_word <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch   <= '0;
            r_roll    <= '0;
            r_heading <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PITCH:   r_pitch   <= i_cfg_data;
                CFG_ROLL:    r_roll    <= i_cfg_data;
                CFG_HEADING: r_heading <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    ald_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (ready[1]),
        .i_take         (ready[1] && r_valid[0]),
        .i_word         (r_word),
        .i_pitch_corr   (r_pitch),
        .i_roll_corr    (r_roll),
        .i_heading_corr (r_heading),
        .o_m            (dec_m),
        .o_meta         (dec_meta)
    );

    ald_divide u_divide (
        .i_clk       (i_clk),
        .i_en        (ready[N_STAGE-1:2]),
        .i_m         (dec_m),
        .i_meta      (dec_meta),
        .o_value     (o_value),
        .o_is_raw    (o_is_raw),
        .o_valid_res (o_valid_res)
    );

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_valid))
        else $error("input stalled while a stage is empty");

    a_raw_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_raw) |-> o_valid_res)
        else $error("raw transaction flagged invalid");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_value == '0 && !o_is_raw))
        else $error("rejected transaction carries data");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_valid[N_STAGE-2]) |=> !o_valid)
        else $error("output valid without an item behind it");

endmodule

FILE: rtl/core/ald_decode.sv
// Label decoder: field extraction, SSM checks, unit numerators and coarse position state.
module ald_decode
    import ald_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  logic                     i_take,
    input  logic [31:0]              i_word,
    input  logic signed [CORR_W-1:0] i_pitch_corr,
    input  logic signed [CORR_W-1:0] i_roll_corr,
    input  logic signed [CORR_W-1:0] i_heading_corr,
    output logic signed [M_W-1:0]    o_m,
    output t_meta                    o_meta
);

    logic [31:0]              w;
    logic [7:0]               lbl;
    logic                     bnr_ok, bcd_ok, minus;
    logic signed [M_W-1:0]    d8, d12, d14, d16, d18, d20, d22, d24;
    logic signed [M_W-1:0]    h26_3, h26_2, b28;
    logic signed [M_W-1:0]    f27_13, f28_13, f27_9, f28_8, f27_17, f27_10, x10;
    logic signed [M_W-1:0]    c_pitch, c_roll, c_heading, lat_x, lon_x;

    logic signed [COARSE_W-1:0] r_lat, r_lon;
    logic                       r_lat_ok, r_lat_neg, r_lon_ok, r_lon_neg;
    logic signed [M_W-1:0]      r_m, n_m;
    t_meta                      r_meta, n_meta;

    assign w      = i_word;
    assign lbl    = w[7:0];
    assign bnr_ok = w[30:29] == SSM_MINUS;
    assign bcd_ok = w[30:29] != SSM_NO_DATA && w[30:29] != SSM_TEST;
    assign minus  = w[30:29] == SSM_MINUS;

    assign d8     = {{(M_W-4){1'b0}}, w[11:8]};
    assign d12    = {{(M_W-4){1'b0}}, w[15:12]};
    assign d14    = {{(M_W-4){1'b0}}, w[17:14]};
    assign d16    = {{(M_W-4){1'b0}}, w[19:16]};
    assign d18    = {{(M_W-4){1'b0}}, w[21:18]};
    assign d20    = {{(M_W-4){1'b0}}, w[23:20]};
    assign d22    = {{(M_W-4){1'b0}}, w[25:22]};
    assign d24    = {{(M_W-4){1'b0}}, w[27:24]};
    assign h26_3  = {{(M_W-3){1'b0}}, w[28:26]};
    assign h26_2  = {{(M_W-2){1'b0}}, w[27:26]};
    assign b28    = {{(M_W-1){1'b0}}, w[28]};

    assign f27_13 = {{(M_W-15){w[27]}}, w[27:13]};
    assign f28_13 = {{(M_W-16){w[28]}}, w[28:13]};
    assign f27_9  = {{(M_W-19){w[27]}}, w[27:9]};
    assign f28_8  = {{(M_W-21){w[28]}}, w[28:8]};
    assign f27_17 = {{(M_W-11){w[27]}}, w[27:17]};
    assign f27_10 = {{(M_W-18){w[27]}}, w[27:10]};
    assign x10    = {{(M_W-19){w[28]}}, w[28:10]};

    assign c_pitch   = {{(M_W-CORR_W){i_pitch_corr[CORR_W-1]}}, i_pitch_corr};
    assign c_roll    = {{(M_W-CORR_W){i_roll_corr[CORR_W-1]}}, i_roll_corr};
    assign c_heading = {{(M_W-CORR_W){i_heading_corr[CORR_W-1]}}, i_heading_corr};
    assign lat_x     = {{(M_W-COARSE_W){r_lat[COARSE_W-1]}}, r_lat};
    assign lon_x     = {{(M_W-COARSE_W){r_lon[COARSE_W-1]}}, r_lon};

    always_comb begin
        logic signed [M_W-1:0] m, n, corr;
        logic [SH_W-1:0]       sv;
        t_qsel                 qs;
        logic                  ok, raw;
        int                    ei;
        m    = '0;
        n    = '0;
        corr = '0;
        sv   = '0;
        qs   = Q_1;
        ok   = 1'b0;
        raw  = 1'b0;
        unique case (lbl) inside
            LBL_007: begin
                ok = bcd_ok; m = 10 * d22 + d18; qs = Q_10;
            end
            LBL_010, LBL_011: begin
                ok = bcd_ok;
                n  = 600 * (10 * d24 + d20) + 100 * d16 + 10 * d12 + d8;
                if (lbl == LBL_011) begin
                    n = n + 60000 * b28;
                end
                m  = minus ? -n : n; qs = Q_600;
            end
            LBL_012: begin
                ok = bcd_ok;
                m  = (1000 * h26_3 + 100 * d22 + 10 * d18 + d14) * 463; qs = Q_900;
            end
            LBL_013, LBL_014, LBL_044: begin
                ok = bcd_ok;
                n  = 1000 * h26_2 + 100 * d22 + 10 * d18 + d14;
                m  = minus ? 3600 - n : n; qs = Q_10;
            end
            LBL_015: begin
                ok = bcd_ok;
                m  = (100 * h26_2 + 10 * d22 + d18) * 463; qs = Q_900;
            end
            LBL_016: begin
                ok = bcd_ok;
                n  = 100 * h26_2 + 10 * d22 + d18;
                m  = minus ? 360 - n : n;
            end
            LBL_351: begin
                ok = bcd_ok; m = 10 * d18 + d14; qs = Q_10;
            end
            LBL_126: begin
                ok = bnr_ok; m = f27_13;
            end
            LBL_132, LBL_137: begin
                ok = bnr_ok; m = 11 * f28_13 + 720000 * b28; qs = Q_2000;
            end
            LBL_135: begin
                ok = bnr_ok; m = f27_9 * 381; qs = Q_1250; sv = 6'd3;
            end
            LBL_175: begin
                ok = bnr_ok; m = f27_13 * 463; qs = Q_900; sv = 6'd3;
            end
            LBL_300, LBL_301, LBL_302: begin
                ok = bnr_ok; m = f28_8 * 310505940; qs = Q_DEG; sv = 6'd28;
            end
            LBL_303, LBL_304, LBL_305: begin
                ok = bnr_ok; m = f28_8 * 381; qs = Q_1250; sv = 6'd21;
            end
            LBL_254, LBL_255, LBL_310, LBL_311: begin
                ok = bnr_ok; m = f28_8 * 180; sv = 6'd20;
            end
            LBL_256: begin
                ok = bnr_ok && r_lat_ok;
                m  = (lat_x * 2048 + (r_lat_neg ? -f27_17 : f27_17)) * 180; sv = 6'd31;
            end
            LBL_257: begin
                ok = bnr_ok && r_lon_ok;
                m  = (lon_x * 2048 + (r_lon_neg ? -f27_17 : f27_17)) * 180; sv = 6'd31;
            end
            LBL_312: begin
                ok = bnr_ok; m = f27_10 * 463; qs = Q_900; sv = 6'd6;
            end
            LBL_324, LBL_325, LBL_314, LBL_313, LBL_316, LBL_317, LBL_320, LBL_334,
            LBL_321, LBL_322: begin
                ok = bnr_ok;
                if (lbl == LBL_324) begin
                    corr = c_pitch;
                end else if (lbl == LBL_325) begin
                    corr = c_roll;
                end else if (lbl == LBL_314) begin
                    corr = c_heading;
                end
                m = x10 * 180 + corr * 4;
                if (lbl != LBL_324 && lbl != LBL_325 && lbl != LBL_321 && lbl != LBL_322) begin
                    m = m + b28 * 94371840;
                end
                sv = 6'd18;
            end
            LBL_315: begin
                ok = bnr_ok; m = x10 * 463; qs = Q_900; sv = 6'd10;
            end
            LBL_323, LBL_331, LBL_332, LBL_333, LBL_362, LBL_363, LBL_364, LBL_375,
            LBL_376: begin
                ok = bnr_ok; m = x10 * 196133; qs = Q_20000; sv = 6'd16;
            end
            LBL_370: begin
                ok = bnr_ok; m = x10 * 196133; qs = Q_20000; sv = 6'd15;
            end
            LBL_326, LBL_327, LBL_330, LBL_336, LBL_337: begin
                ok = bnr_ok; m = x10; sv = 6'd11;
            end
            LBL_335: begin
                ok = bnr_ok; m = x10 + b28 * 2949120; sv = 6'd13;
            end
            LBL_354: begin
                ok = bnr_ok; m = f27_10;
            end
            LBL_245, LBL_360, LBL_365: begin
                ok = bnr_ok; m = x10 * 381; qs = Q_75000; sv = 6'd3;
            end
            LBL_261, LBL_361: begin
                ok = bnr_ok; m = f28_8 * 381; qs = Q_1250; sv = 6'd3;
            end
            LBL_264: begin
                ok = bnr_ok; m = f27_10 * 1852; sv = 6'd14;
            end
            LBL_266, LBL_267: begin
                ok = bnr_ok; m = f28_13 * 463; qs = Q_900; sv = 6'd3;
            end
            LBL_366, LBL_367: begin
                ok = bnr_ok; m = x10 * 463; qs = Q_900; sv = 6'd6;
            end
            default: begin
                raw = 1'b1;
            end
        endcase

        ei = OUT_FRAC_BITS - int'(sv);
        if (raw) begin
            m  = x10;
            qs = Q_1;
            ei = 0;
        end else if (!ok) begin
            m = '0;
        end

        n_m         = m;
        n_meta.raw  = raw;
        n_meta.ok   = ok;
        n_meta.neg  = m[M_W-1];
        n_meta.qsel = qs;
        n_meta.shl  = (ei > 0) ? SH_W'(ei + 1) : SH_W'(1);
        n_meta.k    = (ei < 0) ? SH_W'(-ei) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat     <= '0;
            r_lat_ok  <= 1'b0;
            r_lat_neg <= 1'b0;
            r_lon     <= '0;
            r_lon_ok  <= 1'b0;
            r_lon_neg <= 1'b0;
        end else if (i_take) begin
            if (lbl == LBL_254) begin
                r_lat_ok <= bnr_ok;
                if (bnr_ok) begin
                    r_lat     <= w[28:8];
                    r_lat_neg <= w[28];
                end
            end
            if (lbl == LBL_255) begin
                r_lon_ok <= bnr_ok;
                if (bnr_ok) begin
                    r_lon     <= w[28:8];
                    r_lon_neg <= w[28];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_m    <= n_m;
            r_meta <= n_meta;
        end
    end

    assign o_m    = r_m;
    assign o_meta = r_meta;

endmodule

FILE: rtl/core/ald_divide.sv
// Scaling pipeline: rounding numerator, reciprocal multiply, remainder fix-up, saturation.
module ald_divide
    import ald_pkg::*;
(
    input  logic                    i_clk,
    input  logic [4:0]              i_en,
    input  logic signed [M_W-1:0]   i_m,
    input  t_meta                   i_meta,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_is_raw,
    output logic                    o_valid_res
);

    logic [M_W-1:0]   mag;
    logic [63:0]      n_num, rcp3, pll, plh, phl, phh;
    logic [65:0]      mid;
    logic [31:0]      q3, q5, q6;
    logic [63:0]      qf, qs;

    logic [63:0]      r_num2, r_num3, r_num4;
    t_meta            r_meta2, r_meta3, r_meta4, r_meta5;
    logic [63:0]      r_pll, r_plh, r_phl, r_phh;
    logic [63:0]      r_qe4, r_qe5;
    logic [31:0]      r_rem5;
    logic [VAL_W-1:0] r_value;
    logic             r_raw, r_ok;

    assign mag   = i_meta.neg ? M_W'(-i_m) : M_W'(i_m);
    assign n_num = ({{(64-M_W){1'b0}}, mag} << i_meta.shl)
                 + ({32'b0, q_value(i_meta.qsel)} << i_meta.k);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_num2  <= n_num;
            r_meta2 <= i_meta;
        end
    end

    assign rcp3 = q_recip(r_meta2.qsel);
    assign pll  = r_num2[31:0]  * rcp3[31:0];
    assign plh  = r_num2[31:0]  * rcp3[63:32];
    assign phl  = r_num2[63:32] * rcp3[31:0];
    assign phh  = r_num2[63:32] * rcp3[63:32];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pll   <= pll;
            r_plh   <= plh;
            r_phl   <= phl;
            r_phh   <= phh;
            r_num3  <= r_num2;
            r_meta3 <= r_meta2;
        end
    end

    assign mid = {34'b0, r_pll[63:32]} + {2'b0, r_plh} + {2'b0, r_phl};

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_qe4   <= r_phh + {30'b0, mid[65:32]};
            r_num4  <= r_num3;
            r_meta4 <= r_meta3;
        end
    end

    assign q3 = q_value(r_meta4.qsel);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_rem5  <= r_num4[31:0] - 32'(r_qe4[31:0] * q3);
            r_qe5   <= r_qe4;
            r_meta5 <= r_meta4;
        end
    end

    assign q5 = q_value(r_meta5.qsel);
    assign q6 = {26'b0, r_meta5.k} + 32'd1;
    assign qf = r_qe5 + {63'b0, (r_rem5 >= q5)};
    assign qs = qf >> q6;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            if (qs[63]) begin
                r_value <= r_meta5.neg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
                r_value <= r_meta5.neg ? VAL_W'(-qs) : VAL_W'(qs);
            end
            r_raw <= r_meta5.raw;
            r_ok  <= r_meta5.ok || r_meta5.raw;
        end
    end

    assign o_value     = r_value;
    assign o_is_raw    = r_raw;
    assign o_valid_res = r_ok;

endmodule
